// ===== sv/cis_pkg.sv =====
`timescale 1ns / 1ps
package cis_pkg;

    localparam int CAPACITY   = 1024;
    localparam int VALUE_BITS = 32;
    localparam int ADDR_W     = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_FIND   = 1'b1;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic                         kind;
        logic signed [VALUE_BITS-1:0] point;
    } item_t;

    typedef struct packed {
        logic [1:0]                   status;
        logic signed [VALUE_BITS-1:0] range_low;
        logic signed [VALUE_BITS-1:0] range_high;
    } result_t;

    // handshake between the item queue and the engine
    typedef struct packed {
        logic  valid;
        item_t item;
    } front_out_t;

endpackage

// ===== sv/coalescing_interval_set.sv =====
`timescale 1ns / 1ps
// Sorted set of disjoint closed intervals over signed 32-bit points.
// Input channel (push/full): kind selects insert (0) or find (1) of point.
// An item is taken when push is high and full is low; a two-entry queue
// holds items while the engine is busy, so push keeps working during a search.
// Result channel (empty/pop): status, range_low, range_high of the oldest
// result sit on the ports while empty is low; pop takes it.
// Every item gives exactly one result, in order.
// Each item runs a binary search over the stored lows, a read and a compare
// per step, then two neighbor reads and a decision.
// Finds, covered points and neighbor extensions end with the decision.
// A new interval moves every entry above it up by one, and a join of two
// intervals moves them down by one, one entry per cycle through the RAM port.
// One item is worked at a time.
// Reset clears the interval count and both queues; the RAMs are not swept.
// If pop stays low, the held result blocks the engine from starting the
// next item, and the input queue fills and raises full.
module coalescing_interval_set
    import cis_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic                         kind,
    input  logic signed [VALUE_BITS-1:0] point,
    output logic                         empty,
    input  logic                         pop,
    output logic [1:0]                   status,
    output logic signed [VALUE_BITS-1:0] range_low,
    output logic signed [VALUE_BITS-1:0] range_high
);
    front_out_t head;
    item_t      push_item;
    logic       take;
    logic       res_load;
    result_t    res;
    result_t    out_reg;
    logic       out_valid_reg, out_valid_next;

    assign push_item = '{kind: kind, point: point};

    // accept and hold incoming items
    cis_front u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .push_item(push_item), .head(head), .take(take)
    );

    // search, update the table, produce one result per item
    cis_back u_back (
        .clk(clk), .rst_n(rst_n), .head(head), .take(take),
        .res_free(!out_valid_reg), .res_load(res_load), .res(res)
    );

    // hold the result until popped
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end
        if (res_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            out_reg <= res;
        end
    end

    assign empty      = !out_valid_reg;
    assign status     = out_reg.status;
    assign range_low  = out_reg.range_low;
    assign range_high = out_reg.range_high;
endmodule

// ===== sv/cis_ram.sv =====
`timescale 1ns / 1ps
module cis_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// ===== sv/cis_front.sv =====
`timescale 1ns / 1ps
module cis_front
    import cis_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  item_t      push_item,
    output front_out_t head,
    input  logic       take
);
    item_t      slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    logic       do_push, do_take;

    assign full    = (fill_reg == 2'd2);
    assign do_push = push && !full;
    assign do_take = take && (fill_reg != 2'd0);

    assign head.valid = (fill_reg != 2'd0);
    assign head.item  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_take ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + {1'b0, do_push} - {1'b0, do_take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end
endmodule

// ===== sv/cis_back.sv =====
`timescale 1ns / 1ps
module cis_back
    import cis_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  front_out_t head,
    output logic       take,
    input  logic       res_free,
    output logic       res_load,
    output result_t    res
);
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SRCH = 4'd1;
    localparam logic [3:0] S_SCMP = 4'd2;
    localparam logic [3:0] S_PRED = 4'd3;
    localparam logic [3:0] S_SUCC = 4'd4;
    localparam logic [3:0] S_DEC  = 4'd5;
    localparam logic [3:0] S_UP   = 4'd6;
    localparam logic [3:0] S_DOWN = 4'd7;
    localparam logic [3:0] S_DONE = 4'd8;

    logic [3:0]       state_reg, state_next;
    item_t            item_reg, item_next;
    logic [CNT_W-1:0] lo_reg, lo_next, hi_reg, hi_next;
    logic [CNT_W-1:0] mid_reg, mid_next, mid;
    logic [CNT_W-1:0] idx_reg, idx_next, count_reg, count_next;
    logic             pend_reg, pend_next;
    logic [ADDR_W-1:0] waddr_reg, waddr_next;
    logic signed [VALUE_BITS-1:0] pred_lo_reg, pred_lo_next, pred_hi_reg, pred_hi_next;
    logic signed [VALUE_BITS-1:0] succ_lo_reg, succ_lo_next, succ_hi_reg, succ_hi_next;
    result_t          res_reg, res_next;

    logic [ADDR_W-1:0]     raddr, waddr;
    logic                  we_lo, we_hi;
    logic [VALUE_BITS-1:0] wd_lo, wd_hi, rd_lo, rd_hi;

    logic have_pred, have_succ, covered, join_left, join_right;
    logic signed [VALUE_BITS-1:0] pt;

    cis_ram #(.WIDTH(VALUE_BITS), .DEPTH(CAPACITY)) u_lows (
        .clk(clk), .we(we_lo), .waddr(waddr), .wdata(wd_lo), .raddr(raddr), .rdata(rd_lo)
    );
    cis_ram #(.WIDTH(VALUE_BITS), .DEPTH(CAPACITY)) u_highs (
        .clk(clk), .we(we_hi), .waddr(waddr), .wdata(wd_hi), .raddr(raddr), .rdata(rd_hi)
    );

    assign pt         = item_reg.point;
    assign mid        = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign have_pred  = (lo_reg != '0);
    assign have_succ  = (lo_reg < count_reg);
    // wrap of pt-1 / pt+1 at the extremes cannot match: the neighbor order rules it out
    assign covered    = have_pred && (pred_hi_reg >= pt);
    assign join_left  = have_pred && (pred_hi_reg == pt - 1);
    assign join_right = have_succ && (succ_lo_reg == pt + 1);
    assign res        = res_reg;

    always_comb
    begin
        state_next   = state_reg;
        item_next    = item_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        mid_next     = mid_reg;
        idx_next     = idx_reg;
        count_next   = count_reg;
        pend_next    = pend_reg;
        waddr_next   = waddr_reg;
        pred_lo_next = pred_lo_reg;
        pred_hi_next = pred_hi_reg;
        succ_lo_next = succ_lo_reg;
        succ_hi_next = succ_hi_reg;
        res_next     = res_reg;
        take         = 1'b0;
        res_load     = 1'b0;
        raddr        = mid[ADDR_W-1:0];
        waddr        = waddr_reg;
        we_lo        = 1'b0;
        we_hi        = 1'b0;
        wd_lo        = rd_lo;
        wd_hi        = rd_hi;

        case (state_reg)
            S_IDLE:
            begin
                if (head.valid && res_free)
                begin
                    take       = 1'b1;
                    item_next  = head.item;
                    lo_next    = '0;
                    hi_next    = count_reg;
                    state_next = S_SRCH;
                end
            end
            S_SRCH:
            begin
                if (lo_reg < hi_reg)
                begin
                    raddr      = mid[ADDR_W-1:0];
                    mid_next   = mid;
                    state_next = S_SCMP;
                end
                else
                begin
                    // lo_reg now holds the insert position
                    raddr      = ADDR_W'(lo_reg - 1'b1);
                    state_next = S_PRED;
                end
            end
            S_SCMP:
            begin
                if ($signed(rd_lo) <= pt)
                begin
                    lo_next = mid_reg + 1'b1;
                end
                else
                begin
                    hi_next = mid_reg;
                end
                state_next = S_SRCH;
            end
            S_PRED:
            begin
                pred_lo_next = rd_lo;
                pred_hi_next = rd_hi;
                raddr        = lo_reg[ADDR_W-1:0];
                state_next   = S_SUCC;
            end
            S_SUCC:
            begin
                succ_lo_next = rd_lo;
                succ_hi_next = rd_hi;
                state_next   = S_DEC;
            end
            S_DEC:
            begin
                state_next = S_DONE;
                res_next   = '{status: ST_OK, range_low: pt, range_high: pt};
                if (covered)
                begin
                    res_next.range_low  = pred_lo_reg;
                    res_next.range_high = pred_hi_reg;
                end
                else if (item_reg.kind == KIND_FIND)
                begin
                    res_next = '{status: ST_MISS, range_low: '0, range_high: '0};
                end
                else if (join_left && join_right)
                begin
                    res_next.range_low  = pred_lo_reg;
                    res_next.range_high = succ_hi_reg;
                    idx_next            = lo_reg;
                    pend_next           = 1'b0;
                    state_next          = S_DOWN;
                end
                else if (join_left)
                begin
                    res_next.range_low = pred_lo_reg;
                    waddr              = ADDR_W'(lo_reg - 1'b1);
                    we_hi              = 1'b1;
                    wd_hi              = pt;
                end
                else if (join_right)
                begin
                    res_next.range_high = succ_hi_reg;
                    waddr               = lo_reg[ADDR_W-1:0];
                    we_lo               = 1'b1;
                    wd_lo               = pt;
                end
                else if (count_reg == CNT_W'(CAPACITY))
                begin
                    res_next = '{status: ST_FULL, range_low: '0, range_high: '0};
                end
                else
                begin
                    idx_next   = count_reg;
                    pend_next  = 1'b0;
                    state_next = S_UP;
                end
            end
            S_UP:
            begin
                // move entries up by one, from the top down to the insert position
                if (pend_reg)
                begin
                    we_lo = 1'b1;
                    we_hi = 1'b1;
                end
                if (idx_reg > lo_reg)
                begin
                    raddr      = ADDR_W'(idx_reg - 1'b1);
                    pend_next  = 1'b1;
                    waddr_next = idx_reg[ADDR_W-1:0];
                    idx_next   = idx_reg - 1'b1;
                end
                else if (pend_reg)
                begin
                    pend_next = 1'b0;
                end
                else
                begin
                    waddr      = lo_reg[ADDR_W-1:0];
                    we_lo      = 1'b1;
                    we_hi      = 1'b1;
                    wd_lo      = pt;
                    wd_hi      = pt;
                    count_next = count_reg + 1'b1;
                    state_next = S_DONE;
                end
            end
            S_DOWN:
            begin
                // close the gap left by the successor, then widen the predecessor
                if (pend_reg)
                begin
                    we_lo = 1'b1;
                    we_hi = 1'b1;
                end
                if ((idx_reg + 1'b1) < count_reg)
                begin
                    raddr      = ADDR_W'(idx_reg + 1'b1);
                    pend_next  = 1'b1;
                    waddr_next = idx_reg[ADDR_W-1:0];
                    idx_next   = idx_reg + 1'b1;
                end
                else if (pend_reg)
                begin
                    pend_next = 1'b0;
                end
                else
                begin
                    waddr      = ADDR_W'(lo_reg - 1'b1);
                    we_hi      = 1'b1;
                    wd_hi      = succ_hi_reg;
                    count_next = count_reg - 1'b1;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                res_load   = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg    <= item_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        mid_reg     <= mid_next;
        idx_reg     <= idx_next;
        waddr_reg   <= waddr_next;
        pred_lo_reg <= pred_lo_next;
        pred_hi_reg <= pred_hi_next;
        succ_lo_reg <= succ_lo_next;
        succ_hi_reg <= succ_hi_next;
        res_reg     <= res_next;
    end

    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("interval count above capacity");

    a_pend_shift: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (state_reg == S_UP || state_reg == S_DOWN))
        else $error("shift write pending outside a shift");

    a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> (state_reg == S_SRCH))
        else $error("item taken without starting a search");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |-> res_free)
        else $error("result loaded over a waiting result");
endmodule

// ===== verif/cis_checker.sv =====
`timescale 1ns / 1ps
module cis_checker
    import cis_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  logic                         full,
    input  logic                         kind,
    input  logic signed [VALUE_BITS-1:0] point,
    input  logic                         empty,
    input  logic                         pop,
    input  logic [1:0]                   status,
    input  logic signed [VALUE_BITS-1:0] range_low,
    input  logic signed [VALUE_BITS-1:0] range_high,
    output int                           fail_count,
    output int                           pending
);

    // shadow copy of the interval table
    logic signed [VALUE_BITS-1:0] lows  [CAPACITY];
    logic signed [VALUE_BITS-1:0] highs [CAPACITY];
    int                           count;
    result_t                      expected_q [$];

    localparam logic signed [VALUE_BITS-1:0] PT_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};
    localparam logic signed [VALUE_BITS-1:0] PT_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};

    assign pending = expected_q.size();

    function automatic result_t apply_item(logic k, logic signed [VALUE_BITS-1:0] pt);
        result_t r;
        int      lo;
        int      hi;
        int      mid;
        int      pos;
        bit      jl;
        bit      jr;
        lo = 0;
        hi = count;
        while (lo < hi)
        begin
            mid = lo + (hi - lo) / 2;
            if (lows[mid] <= pt) lo = mid + 1;
            else hi = mid;
        end
        pos = lo;
        r = '0;
        if (pos > 0 && highs[pos-1] >= pt)
        begin
            r.range_low  = lows[pos-1];
            r.range_high = highs[pos-1];
            return r;
        end
        if (k == KIND_FIND)
        begin
            r.status = ST_MISS;
            return r;
        end
        // no wrap at the extremes
        jl = pos > 0 && pt != PT_MIN && highs[pos-1] == pt - 1;
        jr = pos < count && pt != PT_MAX && lows[pos] == pt + 1;
        if (jl && jr)
        begin
            highs[pos-1] = highs[pos];
            for (int i = pos; i + 1 < count; i++)
            begin
                lows[i]  = lows[i+1];
                highs[i] = highs[i+1];
            end
            count--;
            r.range_low  = lows[pos-1];
            r.range_high = highs[pos-1];
        end
        else if (jl)
        begin
            highs[pos-1] = pt;
            r.range_low  = lows[pos-1];
            r.range_high = pt;
        end
        else if (jr)
        begin
            lows[pos]    = pt;
            r.range_low  = pt;
            r.range_high = highs[pos];
        end
        else if (count >= CAPACITY)
        begin
            r.status = ST_FULL;
        end
        else
        begin
            for (int i = count; i > pos; i--)
            begin
                lows[i]  = lows[i-1];
                highs[i] = highs[i-1];
            end
            lows[pos]    = pt;
            highs[pos]   = pt;
            count++;
            r.range_low  = pt;
            r.range_high = pt;
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            count      <= 0;
            fail_count <= 0;
            expected_q.delete();
        end
        else
        begin
            if (push && !full)
                expected_q.push_back(apply_item(kind, point));
            if (pop && !empty)
            begin
                if (expected_q.size() == 0)
                begin
                    $display("%0t: unexpected result status=%0d low=%0d high=%0d",
                             $time, status, range_low, range_high);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (want.status !== status || want.range_low !== range_low ||
                        want.range_high !== range_high)
                    begin
                        $display("%0t: mismatch expected status=%0d low=%0d high=%0d,",
                                 $time, want.status, want.range_low, want.range_high);
                        $display("    actual status=%0d low=%0d high=%0d",
                                 status, range_low, range_high);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

// ===== verif/tb_coalescing_interval_set.sv =====
`timescale 1ns / 1ps
module tb_coalescing_interval_set;
    import cis_pkg::*;

    logic                         clk;
    logic                         rst_n;
    logic                         push;
    logic                         full;
    logic                         kind;
    logic signed [VALUE_BITS-1:0] point;
    logic                         empty;
    logic                         pop;
    logic [1:0]                   status;
    logic signed [VALUE_BITS-1:0] range_low;
    logic signed [VALUE_BITS-1:0] range_high;
    int                           fail_count;
    int                           pending;

    // idle percentages for sender and receiver, per phase
    int  send_idle;
    int  recv_idle;
    int  stall_cycles;
    int  inserts_sent;
    int  finds_sent;

    // leave plenty of margin over the worst item, which shifts the whole table
    localparam int WATCHDOG_LIMIT = 20 * CAPACITY;
    localparam logic signed [VALUE_BITS-1:0] PT_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};
    localparam logic signed [VALUE_BITS-1:0] PT_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};

    coalescing_interval_set dut (.*);

    cis_checker checker_i (.*);

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // receiver: pop at random, with the idle share of the current phase
    always @(posedge clk)
    begin
        if (!rst_n) pop <= 1'b0;
        else pop <= ($urandom_range(99) >= recv_idle);
    end

    // watchdog: count cycles in which neither channel moves an item
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty)) stall_cycles <= 0;
            else stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog expired at %0t", $time);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // hold one item on the ports until it is taken; push stays high
    // until the next item or the end of stimulus drops it
    task automatic send_item(logic k, logic signed [VALUE_BITS-1:0] pt);
        while ($urandom_range(99) < send_idle)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push  <= 1'b1;
        kind  <= k;
        point <= pt;
        @(posedge clk);
        while (full) @(posedge clk);
        if (k == KIND_INSERT) inserts_sent++;
        else finds_sent++;
    endtask

    // random point: mostly a narrow window so neighbors meet and join
    function automatic logic signed [VALUE_BITS-1:0] pick_point(int base);
        case ($urandom_range(9))
            0: return $urandom;
            1: return $urandom_range(1) ? PT_MIN + $urandom_range(3) : PT_MAX - $urandom_range(3);
            default: return base + $urandom_range(300);
        endcase
    endfunction

    initial
    begin
        int base;
        push         = 1'b0;
        pop          = 1'b0;
        kind         = KIND_INSERT;
        point        = '0;
        rst_n        = 1'b0;
        stall_cycles = 0;
        send_idle    = 0;
        recv_idle    = 0;
        inserts_sent = 0;
        finds_sent   = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty-table find, extremes, extend, join, covered
        send_item(KIND_FIND, 32'sd0);
        send_item(KIND_INSERT, PT_MIN);
        send_item(KIND_INSERT, PT_MIN + 1);
        send_item(KIND_INSERT, PT_MAX);
        send_item(KIND_INSERT, PT_MAX - 1);
        send_item(KIND_FIND, PT_MIN);
        send_item(KIND_FIND, PT_MAX);
        send_item(KIND_INSERT, 32'sd10);
        send_item(KIND_INSERT, 32'sd12);
        send_item(KIND_INSERT, 32'sd11);
        send_item(KIND_INSERT, 32'sd11);
        send_item(KIND_INSERT, 32'sd9);
        send_item(KIND_INSERT, 32'sd13);
        send_item(KIND_FIND, 32'sd12);
        send_item(KIND_FIND, 32'sd14);
        send_item(KIND_INSERT, -32'sd1);
        send_item(KIND_INSERT, 32'sd0);
        send_item(KIND_FIND, -32'sd2);
        send_item(KIND_INSERT, 32'sh5555_5555);
        send_item(KIND_INSERT, 32'shAAAA_AAAA);

        // random phases with the three idle mixes
        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle = (ph == 0) ? 29 : (ph == 1) ? 69 : 0;
            recv_idle = (ph == 0) ? 69 : (ph == 1) ? 29 : 0;
            base = $urandom_range(1000) - 500;
            for (int n = 0; n < 183; n++)
                send_item($urandom_range(2) == 0 ? KIND_FIND : KIND_INSERT, pick_point(base));
        end
        push <= 1'b0;

        while (pending != 0) @(posedge clk);
        repeat (CAPACITY + 64) @(posedge clk);

        $display("Covered %0d inserts and %0d finds: extremes, extend, join,",
                 inserts_sent, finds_sent);
        $display("covered points, and three sender/receiver idle mixes.");
        if (fail_count == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== coalescing_interval_set.f =====
sv/cis_pkg.sv
sv/cis_ram.sv
sv/cis_front.sv
sv/cis_back.sv
sv/coalescing_interval_set.sv
verif/cis_checker.sv
verif/tb_coalescing_interval_set.sv
